@@ rtl/core/fswe_pkg.sv @@
`timescale 1ns / 1ps
package fswe_pkg;
	localparam int STACK_DEPTH = 1024;
	localparam int POOL_WORDS = 1024;
	localparam int CELL_BITS = 32;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int PA_W = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [4:0] {
		CMD_DOT = 5'd0, CMD_DROP = 5'd1, CMD_DUP = 5'd2, CMD_SWAP = 5'd3,
		CMD_OVER = 5'd4, CMD_ROT = 5'd5, CMD_MROT = 5'd6, CMD_DEPTH = 5'd7,
		CMD_TUCK = 5'd8, CMD_STORE = 5'd9, CMD_FETCH = 5'd10, CMD_PSTORE = 5'd11,
		CMD_HERE = 5'd12, CMD_EMIT = 5'd13, CMD_CR = 5'd14, CMD_KEY = 5'd15,
		CMD_COMPILE = 5'd16, CMD_NOP = 5'd17
	} cmd_t;

	typedef enum logic [1:0] {KIND_NONE = 2'd0, KIND_NUM = 2'd1, KIND_CHAR = 2'd2} kind_t;

	// decoded word handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  key;
		logic [1:0]  need;
		logic        grow;
		logic        compile_only;
	} word_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_EXEC, ST_POOL, ST_OUT
	} exec_state_t;
endpackage

@@ rtl/core/fswe_if.sv @@
`timescale 1ns / 1ps
interface fswe_cmd_if;
	import fswe_pkg::*;
	logic valid;
	logic ready;
	logic [4:0] command;
	logic [7:0] key_char;
	modport source (output valid, command, key_char, input ready);
	modport sink (input valid, command, key_char, output ready);
endinterface

interface fswe_res_if;
	logic valid;
	logic ready;
	logic [1:0] out_kind;
	logic signed [31:0] out_value;
	logic fault;
	logic [10:0] stack_depth;
	modport source (output valid, out_kind, out_value, fault, stack_depth, input ready);
	modport sink (input valid, out_kind, out_value, fault, stack_depth, output ready);
endinterface

@@ rtl/core/fswe_front.sv @@
`timescale 1ns / 1ps
module fswe_front
	import fswe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	fswe_cmd_if.sink cmd,
	output logic     q_valid,
	input  logic     q_pop,
	output word_t    q_word
);
	// two-entry queue of decoded words
	word_t  mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	word_t  dec;
	logic   push;

	always_comb begin
		dec = '0;
		dec.cmd = cmd_t'(cmd.command);
		dec.key = cmd.key_char;
		case (cmd.command)
			CMD_DOT, CMD_DROP, CMD_FETCH, CMD_EMIT: dec.need = 2'd1;
			CMD_DUP: begin dec.need = 2'd1; dec.grow = 1'b1; end
			CMD_SWAP, CMD_STORE, CMD_PSTORE: dec.need = 2'd2;
			CMD_OVER, CMD_TUCK: begin dec.need = 2'd2; dec.grow = 1'b1; end
			CMD_ROT, CMD_MROT: dec.need = 3;
			CMD_DEPTH, CMD_HERE, CMD_KEY: dec.grow = 1'b1;
			CMD_COMPILE: dec.compile_only = 1'b1;
			CMD_CR, CMD_NOP: ;
			default: dec.cmd = CMD_NOP;
		endcase
	end

	assign cmd.ready = (cnt_q != 2'd2);
	assign push = cmd.valid && cmd.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wr_q <= 1'b0; rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

@@ rtl/core/fswe_back.sv @@
`timescale 1ns / 1ps
module fswe_back
	import fswe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_pop,
	input  word_t     q_word,
	fswe_res_if.source res
);
	// top three stack cells live in registers t0 (top), t1, t2; deeper cells in memory
	logic [CELL_BITS-1:0] smem [STACK_DEPTH];
	logic [CELL_BITS-1:0] pmem [POOL_WORDS];

	exec_state_t state_q, state_d;
	logic [SP_W-1:0] sp_q, sp_d;
	logic [CELL_BITS-1:0] t0_q, t1_q, t2_q, t0_d, t1_d, t2_d;
	logic [CELL_BITS-1:0] srd_q, prd_q;
	word_t w_q;
	logic [1:0] kind_q, kind_d;
	logic [31:0] val_q, val_d;
	logic fault_q, fault_d;
	logic dbl_q, dbl_d;
	logic [PA_W-1:0] clr_q;
	logic latch;
	logic s_we; logic [SA_W-1:0] s_wa; logic [CELL_BITS-1:0] s_wd;
	logic s_re; logic [SA_W-1:0] s_ra;
	logic p_we; logic [PA_W-1:0] p_wa; logic [CELL_BITS-1:0] p_wd;
	logic [PA_W-1:0] p_a;
	logic addr_bad;
	logic [SP_W-1:0] depth_n;

	// address cell, value: t1 for store forms, t0 for fetch
	logic [CELL_BITS-1:0] addr_cell;
	assign addr_cell = (w_q.cmd == CMD_FETCH) ? t0_q : t1_q;
	assign addr_bad = ({{(64-CELL_BITS){1'b0}}, addr_cell} >= 64'(POOL_WORDS));
	assign p_a = PA_W'(addr_cell);

	always_ff @(posedge clk) begin
		if (s_we) smem[s_wa] <= s_wd;
		if (s_re) srd_q <= smem[s_ra];
		if (p_we) pmem[p_wa] <= p_wd;
		prd_q <= pmem[p_a];
	end

	always_comb begin
		state_d = state_q; sp_d = sp_q;
		t0_d = t0_q; t1_d = t1_q; t2_d = t2_q;
		kind_d = kind_q; val_d = val_q; fault_d = fault_q;
		dbl_d = dbl_q;
		q_pop = 1'b0; latch = 1'b0;
		s_we = 1'b0; s_wa = '0; s_wd = t2_q; s_re = 1'b0; s_ra = '0;
		p_we = 1'b0; p_wa = p_a; p_wd = '0;
		res.valid = 1'b0;
		depth_n = sp_q;
		case (state_q)
			ST_CLEAR: begin
				// zero the pool one cell per cycle after reset
				p_we = 1'b1; p_wa = clr_q;
				if (clr_q == PA_W'(POOL_WORDS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1; latch = 1'b1; state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				kind_d = KIND_NONE; val_d = '0; fault_d = 1'b0;
				state_d = ST_OUT;
				if (w_q.compile_only || sp_q < SP_W'(w_q.need)) fault_d = 1'b1;
				else if (w_q.grow && sp_q >= SP_W'(STACK_DEPTH)) fault_d = 1'b1;
				else begin
					case (w_q.cmd)
						CMD_DOT, CMD_DROP, CMD_EMIT: begin
							if (w_q.cmd == CMD_DOT) begin
								kind_d = KIND_NUM;
								val_d = 32'($signed(t0_q));
							end else if (w_q.cmd == CMD_EMIT) begin
								kind_d = KIND_CHAR; val_d = {24'd0, t0_q[7:0]};
							end
							t0_d = t1_q; t1_d = t2_q; sp_d = sp_q - 1'b1;
							state_d = ST_READ;
						end
						CMD_DUP, CMD_OVER, CMD_DEPTH, CMD_HERE, CMD_KEY, CMD_TUCK: begin
							// spill t2 to memory at sp-3
							if (sp_q >= SP_W'(3)) begin
								s_we = 1'b1; s_wa = SA_W'(sp_q - SP_W'(3));
							end
							t2_d = t1_q; t1_d = t0_q;
							case (w_q.cmd)
								CMD_DUP: t0_d = t0_q;
								CMD_OVER: t0_d = t1_q;
								CMD_DEPTH: t0_d = CELL_BITS'(sp_q);
								CMD_HERE: t0_d = '0;
								CMD_KEY: t0_d = CELL_BITS'(w_q.key);
								default: begin t0_d = t0_q; t1_d = t1_q; t2_d = t0_q; end
							endcase
							sp_d = sp_q + 1'b1;
						end
						CMD_SWAP: begin t0_d = t1_q; t1_d = t0_q; end
						CMD_ROT: begin t0_d = t2_q; t1_d = t0_q; t2_d = t1_q; end
						CMD_MROT: begin t0_d = t1_q; t1_d = t2_q; t2_d = t0_q; end
						CMD_FETCH, CMD_STORE, CMD_PSTORE: begin
							if (addr_bad) begin
								fault_d = 1'b1;
								if (w_q.cmd == CMD_FETCH) begin
									t0_d = t1_q; t1_d = t2_q; sp_d = sp_q - 1'b1;
								end else begin
									t0_d = t2_q; sp_d = sp_q - SP_W'(2); dbl_d = 1'b1;
								end
								state_d = ST_READ;
							end else state_d = ST_POOL;
						end
						CMD_CR: begin kind_d = KIND_CHAR; val_d = 32'(NEWLINE_CODE); end
						default: ;
					endcase
				end
			end
			ST_POOL: begin
				// pool read data for address now registered
				if (w_q.cmd == CMD_FETCH) begin
					t0_d = prd_q; state_d = ST_OUT;
				end else begin
					p_we = 1'b1;
					p_wd = (w_q.cmd == CMD_STORE) ? t0_q : prd_q + t0_q;
					t0_d = t2_q; sp_d = sp_q - SP_W'(2); dbl_d = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// refill register window from memory after a pop, t1 first on a double pop
				if (dbl_q && sp_q >= SP_W'(2)) begin
					s_re = 1'b1;
					s_ra = SA_W'(sp_q - SP_W'(2));
					state_d = ST_WAIT;
				end else begin
					dbl_d = 1'b0;
					if (sp_q >= SP_W'(3)) begin
						s_re = 1'b1;
						s_ra = SA_W'(sp_q - SP_W'(3));
						state_d = ST_WAIT;
					end else state_d = ST_OUT;
				end
			end
			ST_WAIT: begin
				if (dbl_q) begin
					t1_d = srd_q; dbl_d = 1'b0; state_d = ST_READ;
				end else begin
					t2_d = srd_q; state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				res.valid = 1'b1;
				if (res.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res.out_kind = kind_q;
	assign res.out_value = $signed(val_q);
	assign res.fault = fault_q;
	assign res.stack_depth = 11'(depth_n);

	always_ff @(posedge clk) begin
		if (latch) w_q <= q_word;
		t0_q <= t0_d; t1_q <= t1_d; t2_q <= t2_d;
		kind_q <= kind_d; val_q <= val_d; fault_q <= fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; sp_q <= '0; dbl_q <= 1'b0; clr_q <= '0;
		end else begin
			state_q <= state_d;
			sp_q <= sp_d;
			dbl_q <= dbl_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end
endmodule

@@ rtl/core/forth_stack_word_executor_top.sv @@
`timescale 1ns / 1ps
// channel  | dir | handshake     | payload
// cmd      | in  | valid / ready | command, key_char
// res      | out | valid / ready | out_kind, out_value, fault, stack_depth
//
// per item the back end steps through: take from queue, execute, a pool
// read for @ ! +!, and one stack memory read per cell refilled after pops
// (one for a single pop, two for ! and +!), then the result step
// the front queue holds two items; the source stalls only when both wait
// reset clears stack pointer and queue, then a sweep zeroes all 1024 pool cells
// before the first item runs; a waiting result holds the back end
module forth_stack_word_executor_top
	import fswe_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	fswe_cmd_if.sink   cmd,
	fswe_res_if.source res
);
	logic  q_valid, q_pop;
	word_t q_word;

	fswe_front u_front (.clk, .arst_n, .cmd, .q_valid, .q_pop, .q_word);
	fswe_back  u_back  (.clk, .arst_n, .q_valid, .q_pop, .q_word, .res);

	// a result never exceeds the stack bound
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.stack_depth <= 11'(STACK_DEPTH)) else $error("depth");
	// a shown kind is always one of the named codes
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.out_kind == KIND_NONE || res.out_kind == KIND_NUM ||
			res.out_kind == KIND_CHAR)) else $error("kind");
	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.out_kind) &&
			$stable(res.out_value) && $stable(res.fault) && $stable(res.stack_depth))
		else $error("hold");
endmodule

@@ bench/fswe_tb_if.sv @@
`timescale 1ns / 1ps
// interfaces come from the rtl; this file holds only the bench-side result type
package fswe_tb_pkg;
	import fswe_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] value;
		logic        fault;
		logic [10:0] depth;
	} word_result_t;
endpackage

@@ bench/tb_forth_stack_word_executor_top.sv @@
`timescale 1ns / 1ps
module tb_forth_stack_word_executor_top;
	import fswe_pkg::*;
	import fswe_tb_pkg::*;

	// scoreboard: predicts each word's result on a private stack and pool
	class word_scoreboard;
		logic [31:0] stk[STACK_DEPTH];
		logic [31:0] pool[POOL_WORDS];
		int unsigned depth;
		word_result_t pending[$];
		int errors;

		function new();
			depth = 0;
			errors = 0;
			foreach (pool[i]) pool[i] = '0;
		endfunction

		function void note_word(logic [4:0] cmd, logic [7:0] key);
			word_result_t r;
			int unsigned need;
			int unsigned grow;
			logic [31:0] a;
			logic [31:0] b;
			r = '{KIND_NONE, 32'd0, 1'b0, 11'd0};
			need = 0;
			grow = 0;
			case (cmd)
				CMD_DOT, CMD_DROP, CMD_FETCH, CMD_EMIT: need = 1;
				CMD_DUP: begin need = 1; grow = 1; end
				CMD_SWAP, CMD_STORE, CMD_PSTORE: need = 2;
				CMD_OVER, CMD_TUCK: begin need = 2; grow = 1; end
				CMD_ROT, CMD_MROT: need = 3;
				CMD_DEPTH, CMD_HERE, CMD_KEY: grow = 1;
				default: ;
			endcase
			if (cmd == CMD_COMPILE || depth < need || (grow != 0 && depth >= STACK_DEPTH))
				r.fault = 1'b1;
			else begin
				case (cmd)
					CMD_DOT: begin
						depth--;
						r.kind = KIND_NUM;
						r.value = stk[depth];
					end
					CMD_DROP: depth--;
					CMD_DUP: begin stk[depth] = stk[depth-1]; depth++; end
					CMD_SWAP: begin
						a = stk[depth-2];
						stk[depth-2] = stk[depth-1];
						stk[depth-1] = a;
					end
					CMD_OVER: begin stk[depth] = stk[depth-2]; depth++; end
					CMD_ROT: begin
						a = stk[depth-3];
						stk[depth-3] = stk[depth-2];
						stk[depth-2] = stk[depth-1];
						stk[depth-1] = a;
					end
					CMD_MROT: begin
						a = stk[depth-1];
						stk[depth-1] = stk[depth-2];
						stk[depth-2] = stk[depth-3];
						stk[depth-3] = a;
					end
					CMD_DEPTH: begin stk[depth] = 32'(depth); depth++; end
					CMD_TUCK: begin
						a = stk[depth-2];
						b = stk[depth-1];
						stk[depth-2] = b;
						stk[depth-1] = a;
						stk[depth] = b;
						depth++;
					end
					CMD_STORE, CMD_PSTORE: begin
						b = stk[depth-1];
						a = stk[depth-2];
						depth -= 2;
						if (a >= POOL_WORDS)
							r.fault = 1'b1;
						else if (cmd == CMD_STORE)
							pool[a] = b;
						else
							pool[a] = pool[a] + b;
					end
					CMD_FETCH: begin
						a = stk[depth-1];
						if (a >= POOL_WORDS) begin
							depth--;
							r.fault = 1'b1;
						end else
							stk[depth-1] = pool[a];
					end
					CMD_HERE: begin stk[depth] = '0; depth++; end
					CMD_EMIT: begin
						depth--;
						r.kind = KIND_CHAR;
						r.value = {24'd0, stk[depth][7:0]};
					end
					CMD_CR: begin
						r.kind = KIND_CHAR;
						r.value = {24'd0, NEWLINE_CODE};
					end
					CMD_KEY: begin stk[depth] = {24'd0, key}; depth++; end
					default: ;
				endcase
			end
			r.depth = 11'(depth);
			pending.push_back(r);
		endfunction

		function void check_result(logic [1:0] kind, logic [31:0] value, logic fault,
				logic [10:0] sdepth);
			word_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result kind=%0d value=%0d", kind, value);
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind || value !== e.value || fault !== e.fault ||
					sdepth !== e.depth) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp kind=%0d val=%h fault=%0b depth=%0d, %s",
						e.kind, e.value, e.fault, e.depth,
						$sformatf("got kind=%0d val=%h fault=%0b depth=%0d",
							kind, value, fault, sdepth));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fswe_cmd_if cmd();
	fswe_res_if res();

	forth_stack_word_executor_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.res(res.source)
	);

	word_scoreboard board;
	// idle percentages for sender and receiver, changed between phases
	int send_idle_pct;
	int recv_idle_pct;
	bit send_done;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random back-pressure, check every accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready)
				board.check_result(res.out_kind, res.out_value, res.fault, res.stack_depth);
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// drive one word; holds valid until accepted, optional idle gap first
	task automatic send_word(input logic [4:0] c, input logic [7:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= c;
		cmd.key_char <= k;
		do @(posedge clk); while (!cmd.ready);
		board.note_word(c, k);
	endtask

	// push the given byte onto the stack via KEY
	task automatic push_byte(input logic [7:0] k);
		send_word(CMD_KEY, k);
	endtask

	// pick a word; well-formed most of the time, out-of-range codes now and then
	function automatic logic [4:0] pick_word(int unsigned sdepth);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return 5'($urandom_range(31, 18));
		if (r < 6)
			return CMD_COMPILE;
		// keep depth moderate: push more when shallow
		if (sdepth < 3 && r < 60)
			return ($urandom_range(1)) ? CMD_KEY : CMD_HERE;
		return 5'($urandom_range(17));
	endfunction

	task automatic run_random(input int n);
		logic [4:0] c;
		for (int i = 0; i < n; i++) begin
			c = pick_word(board.depth);
			// memory words usually get a small valid address, then for stores a value, at times swapped
			if ((c == CMD_STORE || c == CMD_PSTORE || c == CMD_FETCH) &&
					$urandom_range(3) != 0) begin
				push_byte(8'($urandom_range(15)));
				if (c != CMD_FETCH)
					push_byte(8'($urandom));
				if (c != CMD_FETCH && $urandom_range(1))
					send_word(CMD_SWAP, 8'd0);
			end
			send_word(c, 8'($urandom));
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.command = CMD_NOP;
		cmd.key_char = 8'd0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_done = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: underflow on empty stack, every word but DROP, extremes
		send_word(CMD_DOT, 8'd0);
		send_word(CMD_ROT, 8'd0);
		send_word(CMD_COMPILE, 8'd0);
		send_word(5'd31, 8'd0);
		send_word(CMD_KEY, 8'hff);
		send_word(CMD_KEY, 8'h00);
		send_word(CMD_DEPTH, 8'd0);
		send_word(CMD_ROT, 8'd0);
		send_word(CMD_MROT, 8'd0);
		send_word(CMD_TUCK, 8'd0);
		send_word(CMD_OVER, 8'd0);
		send_word(CMD_SWAP, 8'd0);
		send_word(CMD_DUP, 8'd0);
		send_word(CMD_EMIT, 8'd0);
		send_word(CMD_CR, 8'd0);
		send_word(CMD_HERE, 8'd0);
		send_word(CMD_KEY, 8'd7);
		send_word(CMD_STORE, 8'd0);
		send_word(CMD_HERE, 8'd0);
		send_word(CMD_KEY, 8'd5);
		send_word(CMD_PSTORE, 8'd0);
		send_word(CMD_HERE, 8'd0);
		send_word(CMD_FETCH, 8'd0);
		send_word(CMD_DOT, 8'd0);
		send_word(CMD_NOP, 8'd0);

		// +! adds 255 into pool cell 3
		send_word(CMD_KEY, 8'd3);
		send_word(CMD_KEY, 8'hff);
		send_word(CMD_PSTORE, 8'd0);

		send_idle_pct = 24;
		recv_idle_pct = 53;
		run_random(170);
		send_idle_pct = 53;
		recv_idle_pct = 24;
		run_random(170);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(100);

		// overflow: fill the stack to the top, try two more pushes, then fetch, pops and a store
		for (int i = board.depth; i < STACK_DEPTH; i++)
			send_word(CMD_DEPTH, 8'd0);
		send_word(CMD_DUP, 8'd0);
		send_word(CMD_KEY, 8'd1);
		send_word(CMD_FETCH, 8'd0);
		send_word(CMD_DOT, 8'd0);
		for (int i = 0; i < 4; i++)
			send_word(CMD_DROP, 8'd0);
		send_word(CMD_DOT, 8'd0);
		send_word(CMD_STORE, 8'd0);
		send_word(CMD_DROP, 8'd0);
		cmd.valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
